// ===== design/bpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Request codes, status codes and the configuration width of the buddy page
// allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // width of the total page count register
  localparam int CFG_W = 13;
  localparam logic [CFG_W-1:0] TOTAL_RST = 13'd4096;

  typedef enum logic [1:0] {
    FN_INIT  = 2'd0,
    FN_ALLOC = 2'd1,
    FN_FREE  = 2'd2,
    FN_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_BLOCK  = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_BAD       = 2'd3
  } status_e;

endpackage

// ===== design/buddy_page_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over a pool of NUM_PAGES pages with orders 0..NUM_ORDERS-1.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken when start_i is high and busy_o
// is low, and its result is on the result ports when done_o goes high for one
// cycle; results cannot be held off, so capture them when done_o pulses. The
// free lists live in a link RAM (next block of each list) and the per-page
// used flag and block order in a page info RAM, both with registered reads.
// Init lays out the blocks, then sweeps the page info RAM. Alloc finds and
// pops a block, does one sorted list insert per split whose upper half lies
// in the pool, then marks the block's pages. Free clears the pages, then does
// one list search per merge step and a final sorted insert. Each list search
// or insert steps through its list entry by entry, with one link RAM read per
// entry passed. After reset the block runs a clearing pass over all NUM_PAGES
// entries of the page info RAM with busy_o high; configuration writes are
// taken any time.
// ----------------------------------------------------------------------------
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES  = 4096,
  parameter int NUM_ORDERS = 13
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      func_i,
  input  logic [$clog2(NUM_ORDERS)-1:0]   order_i,
  input  logic [$clog2(NUM_PAGES)-1:0]    page_index_i,
  // result
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [$clog2(NUM_PAGES)-1:0]    block_index_o,
  output logic [$clog2(NUM_ORDERS)-1:0]   block_order_o,
  output logic [$clog2(NUM_PAGES+1)-1:0]  avail_pages_o,
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [CFG_W-1:0]                cfg_data_i
);

  localparam int IDX_W = $clog2(NUM_PAGES);
  localparam int ORD_W = $clog2(NUM_ORDERS);
  localparam int CNT_W = $clog2(NUM_PAGES + 1);
  // link word: top bit marks end of list
  localparam int LW    = IDX_W + 1;
  // wide enough for page sums and any block size
  localparam int WW    = ((IDX_W > NUM_ORDERS) ? IDX_W : NUM_ORDERS) + 1;
  localparam int IW    = ORD_W + 1;

  localparam logic [LW-1:0] NONE   = {1'b1, {IDX_W{1'b0}}};
  localparam logic [WW-1:0] NP     = WW'(NUM_PAGES);
  localparam logic [ORD_W-1:0] TOP = ORD_W'(NUM_ORDERS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAYOUT,
    S_SWEEP,
    S_A_FIND,
    S_A_POP,
    S_A_SPLIT,
    S_F_CHK,
    S_MERGE,
    S_WALK,
    S_WSTEP,
    S_INS,
    S_INS2,
    S_REM_W
  } state_e;

  function automatic logic [WW-1:0] blk(input logic [ORD_W-1:0] k);
    blk = {{(WW-1){1'b0}}, 1'b1} << k;
  endfunction

  function automatic logic [WW-1:0] clamp_np(input logic [WW-1:0] v);
    clamp_np = (v > NP) ? NP : v;
  endfunction

  state_e             state_q;
  func_e              func_q;
  logic [ORD_W-1:0]   ord_q;
  logic [IDX_W-1:0]   pi_q;
  logic [IDX_W-1:0]   b_q;
  logic [ORD_W-1:0]   k_q;
  logic [IDX_W-1:0]   t_q;
  logic [LW-1:0]      cur_q;
  logic [LW-1:0]      prev_q;
  logic               ins_q;
  logic               emit_q;
  logic [WW-1:0]      p_q;
  logic [WW-1:0]      end_q;
  logic [IW-1:0]      wdat_q;
  logic [WW-1:0]      pos_q;
  logic [CNT_W-1:0]   free_q;
  logic [LW-1:0]      head_q [NUM_ORDERS];
  logic [CFG_W-1:0]   total_q;
  logic               done_q;
  status_e            status_q;
  logic [IDX_W-1:0]   bidx_q;
  logic [ORD_W-1:0]   bord_q;

  // memory ports
  logic               link_we;
  logic [IDX_W-1:0]   link_waddr;
  logic [LW-1:0]      link_wdata;
  logic [IDX_W-1:0]   link_raddr;
  logic [LW-1:0]      link_rdata;
  logic               info_we;
  logic [IDX_W-1:0]   info_waddr;
  logic [IW-1:0]      info_wdata;
  logic [IW-1:0]      info_rdata;

  // helpers
  logic [WW-1:0]      n_w;
  logic               lay_ok;
  logic               cur_lt;
  logic               cur_hit;
  logic [ORD_W-1:0]   fk;
  logic               ffound;
  logic [ORD_W-1:0]   km1;
  logic [WW-1:0]      half;
  logic [WW-1:0]      bud;
  logic [WW-1:0]      low_b;
  logic [ORD_W-1:0]   rk;
  logic               misal;
  logic               can_merge;

  bpa_ram #(.W(LW), .D(NUM_PAGES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  bpa_ram #(.W(IW), .D(NUM_PAGES)) u_info_ram (
    .clk_i   (clk_i),
    .we_i    (info_we),
    .waddr_i (info_waddr),
    .wdata_i (info_wdata),
    .raddr_i (page_index_i),
    .rdata_o (info_rdata)
  );

  // pages laid out at init, capped at the pool size
  assign n_w     = clamp_np(WW'(total_q));
  assign lay_ok  = n_w[k_q] && ((pos_q + blk(k_q)) <= NP);
  // list walk compares
  assign cur_lt  = !cur_q[IDX_W] && (cur_q[IDX_W-1:0] < t_q);
  assign cur_hit = !cur_q[IDX_W] && (cur_q[IDX_W-1:0] == t_q);
  assign km1     = k_q - ORD_W'(1);
  assign half    = WW'(b_q) + blk(km1);
  assign bud     = WW'(b_q) ^ blk(k_q);
  // lower of the block and its buddy
  assign low_b   = WW'(b_q) & ~blk(k_q);
  assign rk      = info_rdata[ORD_W-1:0];
  assign misal   = (WW'(pi_q) & (blk(rk) - WW'(1))) != '0;
  assign can_merge = (({1'b0, k_q} + IW'(1)) < IW'(NUM_ORDERS)) && (bud < NP);

  // smallest non-empty order at or above the request
  always_comb begin
    fk     = '0;
    ffound = 1'b0;
    for (int j = NUM_ORDERS - 1; j >= 0; j--) begin
      if ((j >= int'(ord_q)) && !head_q[j][IDX_W]) begin
        fk     = ORD_W'(j);
        ffound = 1'b1;
      end
    end
  end

  // memory port control
  always_comb begin
    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    link_raddr = cur_q[IDX_W-1:0];
    info_we    = 1'b0;
    info_waddr = p_q[IDX_W-1:0];
    info_wdata = wdat_q;
    case (state_q)
      S_LAYOUT: begin
        // a new block is alone on its list
        link_we    = lay_ok;
        link_waddr = pos_q[IDX_W-1:0];
        link_wdata = NONE;
      end
      S_SWEEP: begin
        info_we = 1'b1;
      end
      S_A_FIND: begin
        link_raddr = head_q[fk][IDX_W-1:0];
      end
      S_WALK: begin
        if (!cur_lt && !ins_q) begin
          link_raddr = t_q;
        end
      end
      S_INS: begin
        link_we    = 1'b1;
        link_waddr = t_q;
        link_wdata = cur_q;
      end
      S_INS2: begin
        link_we    = 1'b1;
        link_waddr = prev_q[IDX_W-1:0];
        link_wdata = {1'b0, t_q};
      end
      S_REM_W: begin
        // unlink the buddy from its predecessor
        link_we    = !prev_q[IDX_W];
        link_waddr = prev_q[IDX_W-1:0];
        link_wdata = link_rdata;
      end
      default: begin
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RST;
    end else if (cfg_valid_i) begin
      total_q <= cfg_data_i;
    end
  end

  // request sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // clearing pass over the page info RAM
      state_q  <= S_SWEEP;
      func_q   <= FN_INIT;
      emit_q   <= 1'b0;
      p_q      <= '0;
      end_q    <= NP;
      wdat_q   <= '0;
      pos_q    <= '0;
      free_q   <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      bidx_q   <= '0;
      bord_q   <= '0;
      ord_q    <= '0;
      pi_q     <= '0;
      b_q      <= '0;
      k_q      <= '0;
      t_q      <= '0;
      cur_q    <= NONE;
      prev_q   <= NONE;
      ins_q    <= 1'b0;
      for (int j = 0; j < NUM_ORDERS; j++) begin
        head_q[j] <= NONE;
      end
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            func_q <= func_e'(func_i);
            ord_q  <= order_i;
            pi_q   <= page_index_i;
            bidx_q <= '0;
            bord_q <= '0;
            case (func_e'(func_i))
              FN_INIT: begin
                for (int j = 0; j < NUM_ORDERS; j++) begin
                  head_q[j] <= NONE;
                end
                k_q     <= TOP;
                pos_q   <= '0;
                state_q <= S_LAYOUT;
              end
              FN_ALLOC: begin
                if (int'(order_i) >= NUM_ORDERS) begin
                  done_q   <= 1'b1;
                  status_q <= ST_BAD;
                end else begin
                  state_q <= S_A_FIND;
                end
              end
              FN_FREE: begin
                state_q <= S_F_CHK;
              end
              default: begin
                done_q   <= 1'b1;
                status_q <= ST_BAD;
              end
            endcase
          end
        end

        S_LAYOUT: begin
          if (lay_ok) begin
            head_q[k_q] <= {1'b0, pos_q[IDX_W-1:0]};
            pos_q       <= pos_q + blk(k_q);
          end
          if (k_q == '0) begin
            p_q     <= '0;
            end_q   <= NP;
            wdat_q  <= '0;
            state_q <= S_SWEEP;
          end else begin
            k_q <= km1;
          end
        end

        S_SWEEP: begin
          p_q <= p_q + WW'(1);
          if ((p_q + WW'(1)) >= end_q) begin
            case (func_q)
              FN_INIT: begin
                free_q   <= pos_q[CNT_W-1:0];
                done_q   <= emit_q;
                status_q <= ST_OK;
                emit_q   <= 1'b1;
                state_q  <= S_IDLE;
              end
              FN_ALLOC: begin
                free_q   <= free_q - CNT_W'(blk(ord_q));
                done_q   <= 1'b1;
                status_q <= ST_OK;
                bidx_q   <= b_q;
                bord_q   <= ord_q;
                state_q  <= S_IDLE;
              end
              FN_FREE: begin
                state_q <= S_MERGE;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end

        S_A_FIND: begin
          if (!ffound) begin
            done_q   <= 1'b1;
            status_q <= ST_NO_BLOCK;
            state_q  <= S_IDLE;
          end else begin
            b_q     <= head_q[fk][IDX_W-1:0];
            k_q     <= fk;
            state_q <= S_A_POP;
          end
        end

        S_A_POP: begin
          head_q[k_q] <= link_rdata;
          state_q     <= S_A_SPLIT;
        end

        S_A_SPLIT: begin
          if (k_q == ord_q) begin
            p_q     <= WW'(b_q);
            end_q   <= clamp_np(WW'(b_q) + blk(ord_q));
            wdat_q  <= {1'b1, ord_q};
            state_q <= S_SWEEP;
          end else begin
            k_q <= km1;
            if (half < NP) begin
              // upper half goes back on the next lower list
              t_q     <= half[IDX_W-1:0];
              ins_q   <= 1'b1;
              cur_q   <= head_q[km1];
              prev_q  <= NONE;
              state_q <= S_WALK;
            end
          end
        end

        S_F_CHK: begin
          if (WW'(pi_q) >= NP) begin
            done_q   <= 1'b1;
            status_q <= ST_BAD;
            state_q  <= S_IDLE;
          end else if (!info_rdata[ORD_W]) begin
            done_q   <= 1'b1;
            status_q <= ST_NOT_ALLOC;
            state_q  <= S_IDLE;
          end else if ((int'(rk) >= NUM_ORDERS) || misal) begin
            done_q   <= 1'b1;
            status_q <= ST_BAD;
            state_q  <= S_IDLE;
          end else begin
            k_q     <= rk;
            b_q     <= pi_q;
            p_q     <= WW'(pi_q);
            end_q   <= clamp_np(WW'(pi_q) + blk(rk));
            wdat_q  <= '0;
            free_q  <= free_q + CNT_W'(blk(rk));
            bidx_q  <= pi_q;
            bord_q  <= rk;
            state_q <= S_SWEEP;
          end
        end

        S_MERGE: begin
          cur_q   <= head_q[k_q];
          prev_q  <= NONE;
          state_q <= S_WALK;
          if (can_merge) begin
            t_q   <= bud[IDX_W-1:0];
            ins_q <= 1'b0;
          end else begin
            t_q   <= b_q;
            ins_q <= 1'b1;
          end
        end

        S_WALK: begin
          if (cur_lt) begin
            prev_q  <= cur_q;
            state_q <= S_WSTEP;
          end else if (ins_q) begin
            state_q <= S_INS;
          end else if (cur_hit) begin
            state_q <= S_REM_W;
          end else begin
            // buddy not free: place the merged block
            t_q    <= b_q;
            ins_q  <= 1'b1;
            cur_q  <= head_q[k_q];
            prev_q <= NONE;
          end
        end

        S_WSTEP: begin
          cur_q   <= link_rdata;
          state_q <= S_WALK;
        end

        S_INS, S_INS2: begin
          if ((state_q == S_INS) && !prev_q[IDX_W]) begin
            state_q <= S_INS2;
          end else begin
            if (state_q == S_INS) begin
              head_q[k_q] <= {1'b0, t_q};
            end
            if (func_q == FN_ALLOC) begin
              state_q <= S_A_SPLIT;
            end else begin
              done_q   <= 1'b1;
              status_q <= ST_OK;
              state_q  <= S_IDLE;
            end
          end
        end

        S_REM_W: begin
          if (prev_q[IDX_W]) begin
            head_q[k_q] <= link_rdata;
          end
          b_q     <= low_b[IDX_W-1:0];
          k_q     <= k_q + ORD_W'(1);
          state_q <= S_MERGE;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign block_index_o = bidx_q;
  assign block_order_o = bord_q;
  assign avail_pages_o = free_q;
  assign cfg_ready_o   = 1'b1;

  // results only come out once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result while busy");

  // free page count never exceeds the pool
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(free_q) <= NP)
    else $error("free page count beyond pool");

  // a list step always follows a compare in the walk state
  a_walk_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WSTEP) |-> ($past(state_q) == S_WALK))
    else $error("list step out of sequence");

  // an accepted init or free keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (func_i == FN_INIT || func_i == FN_FREE)) |=> busy_o)
    else $error("request accepted without work");

endmodule

// ===== design/bpa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
